@@ rtl/core/i2cbs_pkg.sv @@
// Shared types and constants for the I2C master bit sequencer.
// Used by i2cbs_timer and i2c_master_bit_sequencer_core; no dependencies.
`default_nettype none

package i2cbs_pkg;

    localparam int DATA_BITS = 8;
    localparam int BITCNT_W  = $clog2(DATA_BITS + 1);
    localparam int DELAY_W   = 16;

    localparam logic [DELAY_W-1:0] BIT_DELAY_RESET = DELAY_W'(10);

    typedef enum logic [2:0] {
        KIND_IDLE  = 3'd0,
        KIND_START = 3'd1,
        KIND_STOP  = 3'd2,
        KIND_WRITE = 3'd3,
        KIND_ACK   = 3'd4
    } kind_t;

    typedef struct packed {
        logic [2:0]           kind;
        logic [DATA_BITS-1:0] data_byte;
        logic                 line_level;
    } cmd_t;

    typedef struct packed {
        logic sda_level;
        logic scl_level;
        logic nack_seen;
        logic last_phase;
    } phase_t;

endpackage

`default_nettype wire

@@ rtl/core/i2c_master_bit_sequencer_core.sv @@
// I2C master bit sequencer, top level: command decode, bit shifter, phase FSM.
// Depends on i2cbs_pkg and i2cbs_timer.
//
// Usage:
//  - s_* channel takes one bus command per beat (idle release, start, stop,
//    write byte, acknowledge sample). Unknown kinds are taken and dropped.
//  - m_* channel gives one beat per pin phase (SDA/SCL drive, 1 = released),
//    with last_phase set on the final phase of the command.
//  - cfg_wr_en/cfg_wr_data set bit_delay, the tick count each phase is held.
//    Write it only while the block is idle.
//  - Phase flow: after the command beat, ST_LOAD builds the first phase and
//    ST_EMIT offers it. Each phase waits there for the receiver, is held in
//    ST_HOLD until the timer has counted bit_delay down, and then ST_LOAD
//    builds the next one; a new command is taken only after the last hold.
//    A write byte is 25 phases. Receiver stalls and the hold timer set the rate.
//  - The data byte leaves MSB first through a shift register, one bit per
//    three phases.
//  - A stalled receiver simply freezes the sequencer; the phase beat is held
//    in its output register and the line state only moves when it is taken.
//  - Reset: both lines released, bit_delay = 10, sequencer idle.
`default_nettype none

module i2c_master_bit_sequencer_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [i2cbs_pkg::DELAY_W-1:0] cfg_wr_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire i2cbs_pkg::cmd_t               s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output i2cbs_pkg::phase_t                  m_data
);
    import i2cbs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOAD = 4'b0010,
        ST_EMIT = 4'b0100,
        ST_HOLD = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Configuration
    logic [DELAY_W-1:0] bit_delay_reg;

    // Bus line state (what the last taken phase drove)
    logic sda_reg, sda_next;
    logic scl_reg, scl_next;

    // Command context
    logic [2:0]           kind_reg, kind_next;
    logic [DATA_BITS-1:0] shift_reg, shift_next;
    logic                 line_reg, line_next;
    logic [1:0]           phase_reg, phase_next;   // phase within command or bit
    logic [BITCNT_W-1:0]  bits_reg, bits_next;     // data bits still to send

    // Outgoing beat
    phase_t beat_reg, beat_next;
    phase_t beat_calc;

    logic s_fire, m_fire;
    logic kind_ok;
    logic timer_load, timer_done;

    assign s_fire  = s_valid && s_ready;
    assign m_fire  = m_valid && m_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_EMIT);
    assign m_data  = beat_reg;

    assign kind_ok = (s_data.kind == KIND_IDLE)  || (s_data.kind == KIND_START) ||
                     (s_data.kind == KIND_STOP)  || (s_data.kind == KIND_WRITE) ||
                     (s_data.kind == KIND_ACK);

    // Next pin phase from the command context and current line state
    always_comb begin
        beat_calc = '{sda_level: 1'b1, scl_level: 1'b1, nack_seen: 1'b0,
                      last_phase: 1'b1};
        case (kind_reg)
            KIND_IDLE: begin
                beat_calc.last_phase = 1'b1;
            end
            KIND_START: begin
                beat_calc.sda_level  = 1'b0;
                beat_calc.scl_level  = (phase_reg == 2'd0) ? scl_reg : 1'b0;
                beat_calc.last_phase = (phase_reg != 2'd0);
            end
            KIND_STOP: begin
                beat_calc.sda_level  = (phase_reg == 2'd2);
                beat_calc.scl_level  = (phase_reg == 2'd0) ? scl_reg : 1'b1;
                beat_calc.last_phase = (phase_reg == 2'd2);
            end
            KIND_WRITE: begin
                if (bits_reg != '0) begin
                    beat_calc.sda_level  = shift_reg[DATA_BITS-1];
                    beat_calc.last_phase = 1'b0;
                    case (phase_reg)
                        2'd0:    beat_calc.scl_level = scl_reg;
                        2'd1:    beat_calc.scl_level = 1'b1;
                        default: beat_calc.scl_level = 1'b0;
                    endcase
                end else begin
                    // release SDA for the ack slot
                    beat_calc.sda_level  = 1'b1;
                    beat_calc.scl_level  = 1'b0;
                    beat_calc.last_phase = 1'b1;
                end
            end
            KIND_ACK: begin
                beat_calc.nack_seen = line_reg;
                if (phase_reg == 2'd0) begin
                    beat_calc.sda_level  = sda_reg;
                    beat_calc.scl_level  = 1'b1;
                    beat_calc.last_phase = 1'b0;
                end else begin
                    beat_calc.sda_level  = 1'b1;
                    beat_calc.scl_level  = 1'b0;
                    beat_calc.last_phase = 1'b1;
                end
            end
            default: begin
                beat_calc.last_phase = 1'b1;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        sda_next   = sda_reg;
        scl_next   = scl_reg;
        kind_next  = kind_reg;
        shift_next = shift_reg;
        line_next  = line_reg;
        phase_next = phase_reg;
        bits_next  = bits_reg;
        beat_next  = beat_reg;
        timer_load = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    kind_next  = s_data.kind;
                    shift_next = s_data.data_byte;
                    line_next  = s_data.line_level;
                    phase_next = 2'd0;
                    bits_next  = BITCNT_W'(DATA_BITS);
                    if (kind_ok) begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                beat_next  = beat_calc;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (m_fire) begin
                    sda_next   = beat_reg.sda_level;
                    scl_next   = beat_reg.scl_level;
                    timer_load = 1'b1;
                    state_next = ST_HOLD;
                    if (kind_reg == KIND_WRITE && bits_reg != '0) begin
                        if (phase_reg == 2'd2) begin
                            phase_next = 2'd0;
                            bits_next  = bits_reg - BITCNT_W'(1);
                            shift_next = {shift_reg[DATA_BITS-2:0], 1'b0};
                        end else begin
                            phase_next = phase_reg + 2'd1;
                        end
                    end else begin
                        phase_next = phase_reg + 2'd1;
                    end
                end
            end
            ST_HOLD: begin
                if (timer_done) begin
                    state_next = beat_reg.last_phase ? ST_IDLE : ST_LOAD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            bit_delay_reg <= BIT_DELAY_RESET;
            sda_reg       <= 1'b1;
            scl_reg       <= 1'b1;
        end else begin
            state_reg <= state_next;
            sda_reg   <= sda_next;
            scl_reg   <= scl_next;
            if (cfg_wr_en) begin
                bit_delay_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg  <= kind_next;
        shift_reg <= shift_next;
        line_reg  <= line_next;
        phase_reg <= phase_next;
        bits_reg  <= bits_next;
        beat_reg  <= beat_next;
    end

    i2cbs_timer u_timer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (timer_load),
        .delay   (bit_delay_reg),
        .done    (timer_done)
    );

endmodule

`default_nettype wire

@@ rtl/core/i2cbs_timer.sv @@
// Phase hold timer: counts down bit_delay ticks after each pin phase.
// Depends on i2cbs_pkg for the delay width.
`default_nettype none

module i2cbs_timer (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          load,
    input  wire logic [i2cbs_pkg::DELAY_W-1:0] delay,
    output logic                               done
);
    import i2cbs_pkg::*;

    logic [DELAY_W-1:0] count_reg;
    logic [DELAY_W-1:0] count_next;

    always_comb begin
        count_next = count_reg;
        if (load) begin
            count_next = delay;
        end else if (count_reg != '0) begin
            count_next = count_reg - DELAY_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign done = (count_reg == '0);

endmodule

`default_nettype wire

@@ tb/i2c_master_bit_sequencer_core_tb.sv @@
// Self-checking testbench for i2c_master_bit_sequencer_core: bus commands in, pin phases out.
// Depends on i2cbs_pkg and the RTL of the sequencer; needs no files or arguments.
`timescale 1ns / 1ps

module i2c_master_bit_sequencer_core_tb;
    import i2cbs_pkg::*;

    // Kind codes past KIND_ACK are accepted by the block and dropped.
    localparam logic [2:0] KIND_SPARE_LO = 3'd5;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    localparam int          MAX_REPORTS     = 10;
    localparam int          LONG_STALL      = 600;
    localparam int unsigned BIT_DELAY_MAX   = 16'hFFFF;
    localparam int unsigned BIT_DELAY_MIN   = 0;

    // Tracks the SDA/SCL line state and builds the expected phase run of every
    // command beat; checks each phase beat against the oldest expected one.
    class bus_phase_predictor;
        bit     sda_line;
        bit     scl_line;
        phase_t expected_phases[$];
        int     mismatches;

        function new();
            sda_line   = 1'b1;
            scl_line   = 1'b1;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_phases.size();
        endfunction

        function void add_phase(bit sda, bit scl, bit nack);
            phase_t p;
            p.sda_level  = sda;
            p.scl_level  = scl;
            p.nack_seen  = nack;
            p.last_phase = 1'b0;
            expected_phases.push_back(p);
            sda_line = sda;
            scl_line = scl;
        endfunction

        function void take_command(cmd_t c);
            case (c.kind)
                KIND_IDLE: begin
                    add_phase(1'b1, 1'b1, 1'b0);
                end
                KIND_START: begin
                    add_phase(1'b0, scl_line, 1'b0);
                    add_phase(1'b0, 1'b0, 1'b0);
                end
                KIND_STOP: begin
                    add_phase(1'b0, scl_line, 1'b0);
                    add_phase(1'b0, 1'b1, 1'b0);
                    add_phase(1'b1, 1'b1, 1'b0);
                end
                KIND_WRITE: begin
                    for (int i = DATA_BITS - 1; i >= 0; i--) begin
                        add_phase(c.data_byte[i], scl_line, 1'b0);
                        add_phase(c.data_byte[i], 1'b1, 1'b0);
                        add_phase(c.data_byte[i], 1'b0, 1'b0);
                    end
                    add_phase(1'b1, 1'b0, 1'b0);
                end
                KIND_ACK: begin
                    add_phase(sda_line, 1'b1, c.line_level);
                    add_phase(1'b1, 1'b0, c.line_level);
                end
                default: return;
            endcase
            expected_phases[expected_phases.size() - 1].last_phase = 1'b1;
        endfunction

        function void check_phase(phase_t got);
            phase_t want;
            if (expected_phases.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected phase beat sda=%0b scl=%0b nack=%0b last=%0b",
                             $time, got.sda_level, got.scl_level, got.nack_seen,
                             got.last_phase);
                return;
            end
            want = expected_phases.pop_front();
            if (got.sda_level !== want.sda_level || got.scl_level !== want.scl_level ||
                got.nack_seen !== want.nack_seen || got.last_phase !== want.last_phase) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $write("%0t: phase mismatch: expected sda=%0b scl=%0b nack=%0b last=%0b,",
                           $time, want.sda_level, want.scl_level, want.nack_seen,
                           want.last_phase);
                    $display(" got sda=%0b scl=%0b nack=%0b last=%0b",
                             got.sda_level, got.scl_level, got.nack_seen, got.last_phase);
                end
            end
        endfunction
    endclass

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [DELAY_W-1:0]  cfg_wr_data = '0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    cmd_t                s_data      = '0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    phase_t              m_data;

    bus_phase_predictor  predictor   = new();

    // Knobs owned by the main flow, read by the driver and the sink.
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int unsigned cur_delay     = BIT_DELAY_RESET;
    int          commands_sent = 0;
    bit          stall_request = 1'b0;

    // Owned by the sink process only.
    bit          stall_served  = 1'b0;
    int          hold_left     = 0;

    i2c_master_bit_sequencer_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 0;
    end

    // Sink side: m_ready moves on the falling edge. A long stall, once asked
    // for, is counted out here so the block backs up into its input.
    always @(negedge aclk) begin
        if (stall_request && !stall_served) begin
            hold_left    = LONG_STALL;
            stall_served = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready = 1'b0;
        end else begin
            m_ready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Phase beats are taken on the rising edge; NBA updates of the DUT land
    // after this read, so the sampled values are the pre-edge ones.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            predictor.check_phase(m_data);
    end

    // Offer one command beat. Within this task valid only drops when the sender
    // idles; back to back beats keep it high and swap the payload at the falling edge.
    task automatic send_cmd(logic [2:0] kind, logic [DATA_BITS-1:0] data, logic line);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid           = 1'b1;
        s_data.kind       = kind;
        s_data.data_byte  = data;
        s_data.line_level = line;
        do @(posedge aclk); while (!s_ready);
        predictor.take_command(s_data);
        if (kind <= KIND_ACK)
            commands_sent++;
    endtask

    // Drop valid, let every phase drain, then cover the hold timer that still
    // runs after the last phase beat before touching bit_delay.
    task automatic wait_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (predictor.pending() != 0) @(posedge aclk);
        repeat (cur_delay + 5) @(posedge aclk);
    endtask

    task automatic set_bit_delay(int unsigned value);
        wait_drained();
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = DELAY_W'(value);
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
        cur_delay   = value;
    endtask

    // Mostly well-formed transfers (start, one to three bytes each with an ack,
    // stop), sometimes cut short; the rest is loose commands including the
    // unused kinds, which do not count toward the total.
    task automatic run_traffic(int n_commands);
        int target;
        int n_bytes;
        target = commands_sent + n_commands;
        while (commands_sent < target) begin
            if ($urandom_range(0, 99) < 75) begin
                send_cmd(KIND_START, 8'($urandom), 1'($urandom));
                n_bytes = $urandom_range(1, 3);
                for (int i = 0; i < n_bytes; i++) begin
                    send_cmd(KIND_WRITE, 8'($urandom), 1'($urandom));
                    if ($urandom_range(0, 9) != 0)
                        send_cmd(KIND_ACK, 8'($urandom), 1'($urandom));
                end
                if ($urandom_range(0, 9) != 0)
                    send_cmd(KIND_STOP, 8'($urandom), 1'($urandom));
            end else begin
                send_cmd(3'($urandom_range(KIND_IDLE, KIND_SPARE_HI)), 8'($urandom),
                         1'($urandom));
            end
        end
    endtask

    // Safety net: far beyond the slowest legal run.
    initial begin
        #40_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part at the reset bit_delay: every kind, byte extremes,
        // ack with line low/high, repeated start (SCL already low), stop after
        // stop and a write straight after a stop (SCL high), ack while SDA is
        // held low, and the unused kinds.
        send_cmd(KIND_IDLE,  8'h00, 1'b0);
        send_cmd(KIND_START, 8'h00, 1'b0);
        send_cmd(KIND_ACK,   8'h00, 1'b1);
        send_cmd(KIND_WRITE, 8'h00, 1'b0);
        send_cmd(KIND_ACK,   8'h00, 1'b0);
        send_cmd(KIND_WRITE, 8'hFF, 1'b1);
        send_cmd(KIND_ACK,   8'hFF, 1'b1);
        send_cmd(KIND_START, 8'h00, 1'b0);
        send_cmd(KIND_WRITE, 8'h80, 1'b0);
        send_cmd(KIND_WRITE, 8'h01, 1'b0);
        send_cmd(KIND_STOP,  8'h00, 1'b0);
        send_cmd(KIND_STOP,  8'h00, 1'b0);
        send_cmd(KIND_WRITE, 8'hA5, 1'b0);
        send_cmd(KIND_ACK,   8'h5A, 1'b0);
        for (int k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++)
            send_cmd(3'(k), 8'hFF, 1'b1);
        send_cmd(KIND_IDLE,  8'hFF, 1'b1);
        send_cmd(KIND_ACK,   8'h00, 1'b1);
        send_cmd(KIND_STOP,  8'h00, 1'b0);

        // bit_delay at its floor; sender idles 20%, sink 45%.
        set_bit_delay(BIT_DELAY_MIN);
        send_idle_pct = 20;
        recv_idle_pct = 45;
        run_traffic(170);

        // Short random delay, idling swapped.
        set_bit_delay($urandom_range(1, 7));
        send_idle_pct = 45;
        recv_idle_pct = 20;
        run_traffic(170);

        // No idling; the sink goes dark for a long stretch early on so the
        // block fills up and holds off s_ready.
        set_bit_delay($urandom_range(1, 4));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(posedge aclk);
        stall_request = 1'b1;
        run_traffic(160);

        // bit_delay at its ceiling: only a couple of short commands.
        set_bit_delay(BIT_DELAY_MAX);
        send_cmd(KIND_IDLE, 8'h00, 1'b0);
        send_cmd(KIND_ACK,  8'h00, 1'b1);

        wait_drained();
        repeat (5) @(posedge aclk);

        if (predictor.mismatches == 0 && predictor.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/i2cbs_pkg.sv
rtl/core/i2cbs_timer.sv
rtl/core/i2c_master_bit_sequencer_core.sv
tb/i2c_master_bit_sequencer_core_tb.sv
